// ----- src/mfpd_pkg.sv -----
// shared types and constants for the marker framed packet deframer
// no dependencies; imported by the core and by its checker
package mfpd_pkg;

    // marker characters
    localparam logic [7:0] MARK_PCT   = 8'h25;
    localparam logic [7:0] MARK_TILDE = 8'h7E;

    // default payload capacity in bytes
    localparam int MAX_PAYLOAD_DEF = 256;

    // result field widths
    localparam int BYTE_W      = 8;
    localparam int FRAME_LEN_W = 9;
    localparam int LEN_MAX     = (1 << FRAME_LEN_W) - 1;

    // result kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_END     = 1'b1;

    // parser modes
    typedef enum logic [1:0] {
        MODE_HUNT    = 2'd0,
        MODE_FLAGS   = 2'd1,
        MODE_PAYLOAD = 2'd2
    } t_mode;

    // start marker progress
    typedef logic [1:0] t_match;
    localparam t_match MATCH_NONE  = 2'd0;
    localparam t_match MATCH_PCT   = 2'd1;
    localparam t_match MATCH_TILDE = 2'd2;

    // bytes held in the two-byte window
    typedef logic [1:0] t_held;
    localparam t_held HELD_NONE = 2'd0;
    localparam t_held HELD_ONE  = 2'd1;
    localparam t_held HELD_FULL = 2'd2;

endpackage

// ----- src/marker_framed_packet_deframer_core.sv -----
// marker framed packet deframer: start marker hunt, flags capture, payload holdback
// depends on mfpd_pkg
// Takes one received byte per transfer and accepts a new byte in every cycle while
// results are taken. A byte is registered at the input, parsed by one level of
// logic, and its result (if any) lands in an output register. While a finished
// result waits, one more byte is taken into the input register; after that the
// input stalls until the result is taken. Frames open with "%~%" and a flags byte;
// payload bytes pass through a two-byte holdback window so the "~%~" end marker
// is never delivered as payload. The end marker produces one end-of-frame result
// with the flags and the payload length; a payload longer than MAX_PAYLOAD ends
// the frame early with the overflow bit set.
module marker_framed_packet_deframer_core #(
    parameter int MAX_PAYLOAD = mfpd_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_rx_valid,
    output logic                              o_rx_ready,
    input  logic [mfpd_pkg::BYTE_W-1:0]       i_rx_byte,
    output logic                              o_res_valid,
    input  logic                              i_res_ready,
    output logic                              o_kind,
    output logic [mfpd_pkg::BYTE_W-1:0]       o_data_byte,
    output logic [mfpd_pkg::BYTE_W-1:0]       o_frame_flags,
    output logic [mfpd_pkg::FRAME_LEN_W-1:0]  o_frame_length,
    output logic                              o_overflow
);
    import mfpd_pkg::*;

    localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);
    localparam int CMP_W = (CNT_W > FRAME_LEN_W) ? CNT_W : FRAME_LEN_W;

    // input stage
    logic              r_in_valid, n_in_valid;
    logic [BYTE_W-1:0] r_in_byte, n_in_byte;

    // parser state
    t_mode             r_mode, n_mode;
    t_match            r_match, n_match;
    t_held             r_held, n_held;
    logic [BYTE_W-1:0] r_win0, n_win0;
    logic [BYTE_W-1:0] r_win1, n_win1;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [BYTE_W-1:0] r_flags, n_flags;

    // output stage
    logic                   r_out_valid, n_out_valid;
    logic                   r_out_kind, n_out_kind;
    logic [BYTE_W-1:0]      r_out_data, n_out_data;
    logic [BYTE_W-1:0]      r_out_flags, n_out_flags;
    logic [FRAME_LEN_W-1:0] r_out_len, n_out_len;
    logic                   r_out_ovf, n_out_ovf;

    logic                   s_out_free;
    logic                   s_adv;
    logic                   s_in_xfer;
    logic [FRAME_LEN_W-1:0] s_len_sat;
    logic                   s_end_mark;

    // handshake
    assign s_out_free = !r_out_valid || i_res_ready;
    assign s_adv      = r_in_valid && s_out_free;
    assign o_rx_ready = !r_in_valid || s_adv;
    assign s_in_xfer  = i_rx_valid && o_rx_ready;

    // length saturated to the field width
    assign s_len_sat = (CMP_W'(r_count) > CMP_W'(LEN_MAX)) ? FRAME_LEN_W'(LEN_MAX)
                                                           : FRAME_LEN_W'(r_count);

    // end marker across the window and the current byte
    assign s_end_mark = (r_win0 == MARK_TILDE) && (r_win1 == MARK_PCT)
                        && (r_in_byte == MARK_TILDE);

    // input register load
    always_comb begin
        n_in_byte  = r_in_byte;
        n_in_valid = r_in_valid && !s_adv;
        if (s_in_xfer) begin
            n_in_byte  = i_rx_byte;
            n_in_valid = 1'b1;
        end
    end

    // parser next state and result
    always_comb begin
        n_mode      = r_mode;
        n_match     = r_match;
        n_held      = r_held;
        n_win0      = r_win0;
        n_win1      = r_win1;
        n_count     = r_count;
        n_flags     = r_flags;
        n_out_valid = r_out_valid && !i_res_ready;
        n_out_kind  = r_out_kind;
        n_out_data  = r_out_data;
        n_out_flags = r_out_flags;
        n_out_len   = r_out_len;
        n_out_ovf   = r_out_ovf;
        if (s_adv) begin
            unique case (r_mode)
                MODE_FLAGS: begin
                    n_flags = r_in_byte;
                    n_mode  = MODE_PAYLOAD;
                    n_held  = HELD_NONE;
                    n_count = '0;
                end
                MODE_PAYLOAD: begin
                    if (r_held == HELD_NONE) begin
                        n_win0 = r_in_byte;
                        n_held = HELD_ONE;
                    end else if (r_held == HELD_ONE) begin
                        n_win1 = r_in_byte;
                        n_held = HELD_FULL;
                    end else if (s_end_mark || (r_count >= CNT_W'(MAX_PAYLOAD))) begin
                        // frame end, normal or overflow
                        n_out_valid = 1'b1;
                        n_out_kind  = KIND_END;
                        n_out_data  = '0;
                        n_out_flags = r_flags;
                        n_out_len   = s_len_sat;
                        n_out_ovf   = !s_end_mark;
                        n_mode      = MODE_HUNT;
                        n_match     = MATCH_NONE;
                        n_held      = HELD_NONE;
                    end else begin
                        // pass the oldest held byte
                        n_out_valid = 1'b1;
                        n_out_kind  = KIND_PAYLOAD;
                        n_out_data  = r_win0;
                        n_out_flags = r_flags;
                        n_out_len   = '0;
                        n_out_ovf   = 1'b0;
                        n_win0      = r_win1;
                        n_win1      = r_in_byte;
                        n_count     = r_count + 1'b1;
                    end
                end
                default: begin
                    // start marker hunt
                    n_mode = MODE_HUNT;
                    case (r_match)
                        MATCH_PCT: begin
                            if (r_in_byte == MARK_TILDE) begin
                                n_match = MATCH_TILDE;
                            end else if (r_in_byte == MARK_PCT) begin
                                n_match = MATCH_PCT;
                            end else begin
                                n_match = MATCH_NONE;
                            end
                        end
                        MATCH_TILDE: begin
                            n_match = MATCH_NONE;
                            if (r_in_byte == MARK_PCT) begin
                                n_mode = MODE_FLAGS;
                            end
                        end
                        default: begin
                            n_match = (r_in_byte == MARK_PCT) ? MATCH_PCT : MATCH_NONE;
                        end
                    endcase
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_mode      <= MODE_HUNT;
            r_match     <= MATCH_NONE;
            r_held      <= HELD_NONE;
            r_count     <= '0;
            r_flags     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_mode      <= n_mode;
            r_match     <= n_match;
            r_held      <= n_held;
            r_count     <= n_count;
            r_flags     <= n_flags;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_in_byte   <= n_in_byte;
        r_win0      <= n_win0;
        r_win1      <= n_win1;
        r_out_kind  <= n_out_kind;
        r_out_data  <= n_out_data;
        r_out_flags <= n_out_flags;
        r_out_len   <= n_out_len;
        r_out_ovf   <= n_out_ovf;
    end

    assign o_res_valid    = r_out_valid;
    assign o_kind         = r_out_kind;
    assign o_data_byte    = r_out_data;
    assign o_frame_flags  = r_out_flags;
    assign o_frame_length = r_out_len;
    assign o_overflow     = r_out_ovf;

endmodule

// ----- src/mfpd_checker.sv -----
// port-level checks for the deframer core, attached by bind
// depends on mfpd_pkg and marker_framed_packet_deframer_core
module mfpd_checker #(
    parameter int MAX_PAYLOAD = mfpd_pkg::MAX_PAYLOAD_DEF
) (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_res_valid,
    input logic                              i_res_ready,
    input logic                              o_kind,
    input logic [mfpd_pkg::BYTE_W-1:0]       o_data_byte,
    input logic [mfpd_pkg::FRAME_LEN_W-1:0]  o_frame_length,
    input logic                              o_overflow
);
    import mfpd_pkg::*;

    localparam int OVF_LEN = (MAX_PAYLOAD > LEN_MAX) ? LEN_MAX : MAX_PAYLOAD;

    // no result right after reset
    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_res_valid)
        else $error("result valid right after reset");

    // a stalled result stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !i_res_ready |=> o_res_valid && $stable(o_kind)
            && $stable(o_data_byte) && $stable(o_frame_length) && $stable(o_overflow))
        else $error("stalled result changed");

    // payload transfers carry no length and no overflow
    a_payload_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && (o_kind == KIND_PAYLOAD) |-> (o_frame_length == '0) && !o_overflow)
        else $error("payload result with length or overflow");

    // frame end carries a zero data byte
    a_end_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && (o_kind == KIND_END) |-> (o_data_byte == '0))
        else $error("frame end with nonzero data");

    // an overflow end reports the full capacity
    a_ovf_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_overflow |-> (o_kind == KIND_END)
            && (o_frame_length == FRAME_LEN_W'(OVF_LEN)))
        else $error("overflow end with wrong length");

endmodule

bind marker_framed_packet_deframer_core mfpd_checker #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_mfpd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_res_valid    (o_res_valid),
    .i_res_ready    (i_res_ready),
    .o_kind         (o_kind),
    .o_data_byte    (o_data_byte),
    .o_frame_length (o_frame_length),
    .o_overflow     (o_overflow)
);
